// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file egd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("implication assertion failed");

// Next-cycle implication under reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("next-cycle assertion failed");

`endif

// File: hw/rtl/egd_pkg.sv
package egd_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int CNT_W      = $clog2(WORD_WIDTH);
	localparam int ADDR_W     = 4;

	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_GEN     = 2'd1;
	localparam logic [1:0] REG_PUB     = 2'd2;
	localparam logic [1:0] REG_PRIV    = 2'd3;

	localparam logic [31:0] MODULUS_RST = 32'd104729;
	localparam logic [31:0] GEN_RST     = 32'd2;
	localparam logic [31:0] PUB_RST     = 32'd1;
	localparam logic [31:0] PRIV_RST    = 32'd1;

	localparam logic [1:0] POW_GEN  = 2'd0;
	localparam logic [1:0] POW_PUB  = 2'd1;
	localparam logic [1:0] POW_SEC  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_PRE, S_RA, S_RB, S_PW0, S_PW1, S_PWB, S_PWR, S_PWS, S_PWN,
		S_PDN, S_IV, S_IQ, S_IT, S_FE, S_FD, S_DIV, S_MUL, S_FIN
	} state_t;

endpackage

// File: hw/rtl/elgamal_encrypt_decrypt_unit.sv
// ElGamal encrypt/decrypt unit over integers modulo a prime q.
// Keys and group live in four APB registers: modulus, generator,
// public key, private key at byte addresses 0, 4, 8, 12; pready is
// always high and reads return the register value.
// A request is taken when start is high and busy is low: req_type 0
// encrypts message with random_word, req_type 1 decrypts
// (ephemeral_part, masked_body). busy stays high until the result word.
// The result word shows on first_part, second_part, status for exactly
// one cycle with done high; the receiver cannot stall it.
// All arithmetic runs on one 32-step modular multiplier (shift-add)
// and one 32-step restoring divider under a sequencer. Each
// exponentiation scans 32 exponent bits with a squaring per bit and
// a product per set bit. A decrypt also computes a modular inverse
// by extended Euclid steps.
// Reset clears the sequencer to idle and loads the register defaults.
module elgamal_encrypt_decrypt_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [egd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] message,
	input  logic [31:0] random_word,
	input  logic [31:0] ephemeral_part,
	input  logic [31:0] masked_body,
	output logic        done,
	output logic [31:0] first_part,
	output logic [31:0] second_part,
	output logic        status
);

	localparam int W = egd_pkg::WORD_WIDTH;
	localparam int C = egd_pkg::CNT_W;

	logic [W-1:0] modulus_q, generator_q, pub_key_q, priv_key_q;
	egd_pkg::state_t st_q, st_d, ret_q;
	logic [1:0]   pw_sel_q;
	logic         dec_q;
	logic [W-1:0] a_q, b_q, c1_q, base_q, r_q, e_q;
	logic [C-1:0] bcnt_q;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q, rn_q;
	logic [W-1:0] dn_q, dd_q, rem_q, quo_q;
	logic [W-1:0] ma_q, mb_q, acc_q;
	logic [C-1:0] cnt_q;
	logic [W-1:0] first_q, second_q;
	logic         status_q;

	logic [W:0]   div_trial, mul_t2, mul_t3, mul_t2r;
	logic         div_ge;
	logic [W-1:0] mul_nx, qt_red, tn, base_src;
	logic         cfg_wr, cnt_end;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= egd_pkg::MODULUS_RST[W-1:0];
			generator_q <= egd_pkg::GEN_RST[W-1:0];
			pub_key_q   <= egd_pkg::PUB_RST[W-1:0];
			priv_key_q  <= egd_pkg::PRIV_RST[W-1:0];
		end else if (cfg_wr) begin
			case (paddr[3:2])
				egd_pkg::REG_MODULUS: modulus_q   <= pwdata[W-1:0];
				egd_pkg::REG_GEN:     generator_q <= pwdata[W-1:0];
				egd_pkg::REG_PUB:     pub_key_q   <= pwdata[W-1:0];
				egd_pkg::REG_PRIV:    priv_key_q  <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			egd_pkg::REG_MODULUS: prdata = modulus_q;
			egd_pkg::REG_GEN:     prdata = generator_q;
			egd_pkg::REG_PUB:     prdata = pub_key_q;
			egd_pkg::REG_PRIV:    prdata = priv_key_q;
			default:              prdata = '0;
		endcase
	end

	// divider step
	assign div_trial = {rem_q, dn_q[W-1]};
	assign div_ge    = div_trial >= {1'b0, dd_q};

	// multiplier step: acc = 2*acc + bit*a mod q
	assign mul_t2  = {acc_q, 1'b0};
	assign mul_t2r = (mul_t2 >= {1'b0, modulus_q}) ? mul_t2 - {1'b0, modulus_q} : mul_t2;
	assign mul_t3  = mul_t2r + (mb_q[W-1] ? {1'b0, ma_q} : '0);
	always_comb begin
		if (mul_t3 >= {1'b0, modulus_q}) mul_nx = W'(mul_t3 - {1'b0, modulus_q});
		else mul_nx = mul_t3[W-1:0];
	end

	assign cnt_end = cnt_q == C'(W - 1);
	assign qt_red  = (quo_q >= modulus_q) ? quo_q - modulus_q : quo_q;
	assign tn      = (t0_q >= acc_q) ? t0_q - acc_q : t0_q + (modulus_q - acc_q);

	always_comb begin
		case (pw_sel_q)
			egd_pkg::POW_GEN: base_src = generator_q;
			egd_pkg::POW_PUB: base_src = pub_key_q;
			default:          base_src = a_q;
		endcase
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			egd_pkg::S_IDLE: if (start) st_d = egd_pkg::S_PRE;
			egd_pkg::S_PRE:  st_d = (modulus_q < W'(2)) ? egd_pkg::S_FIN : egd_pkg::S_DIV;
			egd_pkg::S_RA:   st_d = egd_pkg::S_DIV;
			egd_pkg::S_RB:   st_d = egd_pkg::S_PW0;
			egd_pkg::S_PW0:  st_d = egd_pkg::S_DIV;
			egd_pkg::S_PW1:  st_d = egd_pkg::S_PWB;
			egd_pkg::S_PWB:  st_d = e_q[0] ? egd_pkg::S_MUL : egd_pkg::S_PWS;
			egd_pkg::S_PWR:  st_d = egd_pkg::S_PWS;
			egd_pkg::S_PWS:  st_d = egd_pkg::S_MUL;
			egd_pkg::S_PWN:
				st_d = (bcnt_q == C'(W - 1)) ? egd_pkg::S_PDN : egd_pkg::S_PWB;
			egd_pkg::S_PDN: begin
				case (pw_sel_q)
					egd_pkg::POW_GEN: st_d = egd_pkg::S_PW0;
					egd_pkg::POW_PUB: st_d = egd_pkg::S_MUL;
					default:          st_d = egd_pkg::S_IV;
				endcase
			end
			egd_pkg::S_IV: begin
				if (r1_q != '0) st_d = egd_pkg::S_DIV;
				else if (r0_q == W'(1)) st_d = egd_pkg::S_MUL;
				else st_d = egd_pkg::S_FIN;
			end
			egd_pkg::S_IQ:   st_d = egd_pkg::S_MUL;
			egd_pkg::S_IT:   st_d = egd_pkg::S_IV;
			egd_pkg::S_FE:   st_d = egd_pkg::S_FIN;
			egd_pkg::S_FD:   st_d = egd_pkg::S_FIN;
			egd_pkg::S_DIV:  if (cnt_end) st_d = ret_q;
			egd_pkg::S_MUL:  if (cnt_end) st_d = ret_q;
			egd_pkg::S_FIN:  st_d = egd_pkg::S_IDLE;
			default:         st_d = egd_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= egd_pkg::S_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		busy = st_q != egd_pkg::S_IDLE;
		done = st_q == egd_pkg::S_FIN;
	end

	assign first_part  = first_q;
	assign second_part = second_q;
	assign status      = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q    <= egd_pkg::S_IDLE;
			pw_sel_q <= egd_pkg::POW_GEN;
			dec_q    <= 1'b0;
			cnt_q    <= '0;
			bcnt_q   <= '0;
			a_q      <= '0;
			b_q      <= '0;
			c1_q     <= '0;
			base_q   <= '0;
			r_q      <= '0;
			e_q      <= '0;
			r0_q     <= '0;
			r1_q     <= '0;
			t0_q     <= '0;
			t1_q     <= '0;
			rn_q     <= '0;
			dn_q     <= '0;
			dd_q     <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			ma_q     <= '0;
			mb_q     <= '0;
			acc_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			status_q <= 1'b0;
		end else begin
			case (st_q)
				egd_pkg::S_IDLE: begin
					if (start) begin
						dec_q    <= req_type;
						a_q      <= req_type ? ephemeral_part : message;
						b_q      <= req_type ? masked_body : random_word;
						first_q  <= '0;
						second_q <= '0;
						status_q <= 1'b0;
					end
				end
				egd_pkg::S_PRE: begin
					status_q <= dec_q;
					dn_q  <= a_q;
					dd_q  <= modulus_q;
					rem_q <= '0;
					cnt_q <= '0;
					ret_q <= egd_pkg::S_RA;
				end
				egd_pkg::S_RA: begin
					a_q   <= rem_q;
					dn_q  <= b_q;
					dd_q  <= dec_q ? modulus_q : modulus_q - W'(1);
					rem_q <= '0;
					cnt_q <= '0;
					ret_q <= egd_pkg::S_RB;
				end
				egd_pkg::S_RB: begin
					b_q      <= dec_q ? rem_q : rem_q + W'(1);
					pw_sel_q <= dec_q ? egd_pkg::POW_SEC : egd_pkg::POW_GEN;
				end
				egd_pkg::S_PW0: begin
					dn_q  <= base_src;
					dd_q  <= modulus_q;
					rem_q <= '0;
					cnt_q <= '0;
					ret_q <= egd_pkg::S_PW1;
				end
				egd_pkg::S_PW1: begin
					base_q <= rem_q;
					r_q    <= W'(1);
					e_q    <= (pw_sel_q == egd_pkg::POW_SEC) ? priv_key_q : b_q;
					bcnt_q <= '0;
				end
				egd_pkg::S_PWB: begin
					ma_q  <= base_q;
					mb_q  <= r_q;
					acc_q <= '0;
					cnt_q <= '0;
					ret_q <= egd_pkg::S_PWR;
				end
				egd_pkg::S_PWR: r_q <= acc_q;
				egd_pkg::S_PWS: begin
					ma_q  <= base_q;
					mb_q  <= base_q;
					acc_q <= '0;
					cnt_q <= '0;
					ret_q <= egd_pkg::S_PWN;
				end
				egd_pkg::S_PWN: begin
					base_q <= acc_q;
					e_q    <= e_q >> 1;
					bcnt_q <= bcnt_q + C'(1);
				end
				egd_pkg::S_PDN: begin
					case (pw_sel_q)
						egd_pkg::POW_GEN: begin
							c1_q     <= r_q;
							pw_sel_q <= egd_pkg::POW_PUB;
						end
						egd_pkg::POW_PUB: begin
							ma_q  <= a_q;
							mb_q  <= r_q;
							acc_q <= '0;
							cnt_q <= '0;
							ret_q <= egd_pkg::S_FE;
						end
						default: begin
							r0_q <= modulus_q;
							r1_q <= r_q;
							t0_q <= '0;
							t1_q <= W'(1);
						end
					endcase
				end
				egd_pkg::S_IV: begin
					if (r1_q != '0) begin
						dn_q  <= r0_q;
						dd_q  <= r1_q;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						ret_q <= egd_pkg::S_IQ;
					end else begin
						ma_q  <= b_q;
						mb_q  <= t0_q;
						acc_q <= '0;
						cnt_q <= '0;
						ret_q <= egd_pkg::S_FD;
					end
				end
				egd_pkg::S_IQ: begin
					rn_q  <= rem_q;
					ma_q  <= qt_red;
					mb_q  <= t1_q;
					acc_q <= '0;
					cnt_q <= '0;
					ret_q <= egd_pkg::S_IT;
				end
				egd_pkg::S_IT: begin
					r0_q <= r1_q;
					r1_q <= rn_q;
					t0_q <= t1_q;
					t1_q <= tn;
				end
				egd_pkg::S_FE: begin
					first_q  <= c1_q;
					second_q <= acc_q;
				end
				egd_pkg::S_FD: begin
					first_q  <= acc_q;
					status_q <= 1'b0;
				end
				egd_pkg::S_DIV: begin
					rem_q <= div_ge ? W'(div_trial - {1'b0, dd_q}) : div_trial[W-1:0];
					quo_q <= {quo_q[W-2:0], div_ge};
					dn_q  <= {dn_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + C'(1);
				end
				egd_pkg::S_MUL: begin
					acc_q <= mul_nx;
					mb_q  <= {mb_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + C'(1);
				end
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/egd_checker.sv
`include "assert_macros.svh"

module egd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	`AST_IMPL(a_done_busy, clk, arst_n, done, busy)
	`AST_NEXT(a_take_busy, clk, arst_n, start && !busy, busy)
	`AST_NEXT(a_done_single, clk, arst_n, done, !done)
	`AST_NEXT(a_done_idle, clk, arst_n, done, !busy)

endmodule

bind elgamal_encrypt_decrypt_unit egd_checker u_egd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// File: test/egd_checker.sv
`timescale 1ns / 1ps

module egd_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [egd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic        req_type,
	input  logic [31:0] message,
	input  logic [31:0] random_word,
	input  logic [31:0] ephemeral_part,
	input  logic [31:0] masked_body,
	input  logic        done,
	input  logic [31:0] first_part,
	input  logic [31:0] second_part,
	input  logic        status,
	output int          pending,
	output int          fails
);

	typedef struct packed {
		logic [31:0] first_part;
		logic [31:0] second_part;
		logic        status;
	} cipher_word_t;

	cipher_word_t expected_words[$];
	logic [63:0] q_reg, g_reg, pub_reg, priv_reg;

	function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] q);
		logic [63:0] acc;
		acc = 0;
		while (b != 0) begin
			if (b[0]) begin
				acc = acc + a;
				if (acc >= q) acc = acc - q;
			end
			a = a + a;
			if (a >= q) a = a - q;
			b = b >> 1;
		end
		return acc;
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] q);
		logic [63:0] r;
		r = 1 % q;
		base = base % q;
		while (e != 0) begin
			if (e[0]) r = mulmod(r, base, q);
			base = mulmod(base, base, q);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic bit invmod(logic [63:0] s, logic [63:0] q, output logic [63:0] inv);
		logic [63:0] r0, r1, t0, t1, qt, rn, p, tn;
		r0 = q;
		r1 = s;
		t0 = 0;
		t1 = 1 % q;
		inv = 0;
		while (r1 != 0) begin
			qt = r0 / r1;
			rn = r0 - qt * r1;
			p = mulmod(qt % q, t1, q);
			tn = (t0 >= p) ? (t0 - p) : (t0 + (q - p));
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		if (r0 != 1) return 0;
		inv = t0;
		return 1;
	endfunction

	function automatic cipher_word_t elgamal_result(logic dec, logic [31:0] msg, logic [31:0] rnd,
			logic [31:0] c1_in, logic [31:0] c2_in);
		cipher_word_t w;
		logic [63:0] k, c1, c2, s, inv;
		w = '0;
		if (q_reg < 2) begin
			w.status = dec;
		end else if (!dec) begin
			k = 64'(rnd) % (q_reg - 1) + 1;
			w.first_part = 32'(powmod(g_reg, k, q_reg));
			w.second_part = 32'(mulmod(64'(msg) % q_reg, powmod(pub_reg, k, q_reg), q_reg));
		end else begin
			c1 = 64'(c1_in) % q_reg;
			c2 = 64'(c2_in) % q_reg;
			s = powmod(c1, priv_reg, q_reg);
			if (invmod(s, q_reg, inv)) w.first_part = 32'(mulmod(c2, inv, q_reg));
			else w.status = 1'b1;
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cipher_word_t got, want;
		int nerr;
		nerr = 0;
		if (!arst_n) begin
			q_reg <= 64'(egd_pkg::MODULUS_RST);
			g_reg <= 64'(egd_pkg::GEN_RST);
			pub_reg <= 64'(egd_pkg::PUB_RST);
			priv_reg <= 64'(egd_pkg::PRIV_RST);
			expected_words.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					egd_pkg::REG_MODULUS: q_reg <= 64'(pwdata);
					egd_pkg::REG_GEN: g_reg <= 64'(pwdata);
					egd_pkg::REG_PUB: pub_reg <= 64'(pwdata);
					egd_pkg::REG_PRIV: priv_reg <= 64'(pwdata);
					default: ;
				endcase
			end
			if (start && !busy)
				expected_words.push_back(elgamal_result(req_type, message, random_word,
					ephemeral_part, masked_body));
			if (done) begin
				got = '{first_part, second_part, status};
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					nerr = nerr + 1;
				end else begin
					want = expected_words.pop_front();
					if (got.first_part !== want.first_part) begin
						$error("first_part expected %h actual %h", want.first_part, got.first_part);
						nerr = nerr + 1;
					end
					if (got.second_part !== want.second_part) begin
						$error("second_part expected %h actual %h", want.second_part,
							got.second_part);
						nerr = nerr + 1;
					end
					if (got.status !== want.status) begin
						$error("status expected %b actual %b", want.status, got.status);
						nerr = nerr + 1;
					end
				end
			end
			pending <= expected_words.size();
			fails <= fails + nerr;
		end
	end
endmodule

// File: test/elgamal_encrypt_decrypt_unit_tb.sv
`timescale 1ns / 1ps

module elgamal_encrypt_decrypt_unit_tb;

	localparam logic REQ_ENC = 1'b0;
	localparam logic REQ_DEC = 1'b1;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [egd_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic req_type = 0;
	logic [31:0] message = '0, random_word = '0, ephemeral_part = '0, masked_body = '0;
	logic done;
	logic [31:0] first_part, second_part;
	logic status;
	int pending, fails;

	always #5 clk = ~clk;

	elgamal_encrypt_decrypt_unit dut (.*);

	egd_tb_checker chk (.*);

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = egd_pkg::ADDR_W'({idx, 2'b00});
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic set_keys(logic [31:0] q, logic [31:0] g, logic [31:0] pub, logic [31:0] priv);
		wait (pending == 0 && !busy);
		write_reg(egd_pkg::REG_MODULUS, q);
		write_reg(egd_pkg::REG_GEN, g);
		write_reg(egd_pkg::REG_PUB, pub);
		write_reg(egd_pkg::REG_PRIV, priv);
	endtask

	task automatic send_word(logic rt, logic [31:0] m, logic [31:0] r, logic [31:0] c1,
			logic [31:0] c2);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		req_type = rt;
		message = m;
		random_word = r;
		ephemeral_part = c1;
		masked_body = c2;
		start = 1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		@(negedge clk);
		start = 0;
	endtask

	task automatic random_words(int n, logic [31:0] q);
		logic [31:0] c1;
		repeat (n) begin
			c1 = $urandom();
			case ($urandom_range(0, 9))
				0: c1 = 0;
				1: c1 = q;
				default: ;
			endcase
			send_word(logic'($urandom_range(0, 1)), $urandom(), $urandom(), c1, $urandom());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_word(REQ_ENC, 32'd0, 32'd0, 32'd0, 32'd0);
		send_word(REQ_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_word(REQ_DEC, 32'd0, 32'd0, 32'd0, 32'd5);
		send_word(REQ_DEC, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(REQ_DEC, 32'd0, 32'd0, 32'd104729, 32'd7);
		random_words(10, 32'd104729);

		set_keys(32'd4294967291, 32'd2, $urandom(), $urandom());
		send_word(REQ_ENC, 32'hFFFF_FFFF, 32'd4294967289, 32'd0, 32'd0);
		send_word(REQ_DEC, 32'd0, 32'd0, 32'd4294967291, 32'd1);
		random_words(30, 32'd4294967291);

		set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_word(REQ_ENC, 32'd12345, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_word(REQ_DEC, 32'd0, 32'd0, 32'd3, 32'hFFFF_FFFE);
		random_words(10, 32'hFFFF_FFFF);

		set_keys(32'd1, 32'd1, 32'd1, 32'd1);
		send_word(REQ_ENC, 32'd9, 32'd9, 32'd9, 32'd9);
		send_word(REQ_DEC, 32'd9, 32'd9, 32'd9, 32'd9);
		set_keys(32'd0, 32'd2, 32'd3, 32'd4);
		send_word(REQ_ENC, 32'd9, 32'd9, 32'd9, 32'd9);
		send_word(REQ_DEC, 32'd9, 32'd9, 32'd9, 32'd9);
		set_keys(32'd2, 32'd1, 32'd1, 32'hFFFF_FFFF);
		random_words(6, 32'd2);
		set_keys(32'd3, 32'd2, 32'd2, 32'd1);
		random_words(6, 32'd3);

		set_keys(32'd4294967291, 32'd5, $urandom(), $urandom());
		random_words(30, 32'd4294967291);
		set_keys(32'd65521, 32'd17, $urandom_range(0, 65520), $urandom());
		random_words(30, 32'd65521);

		start = 0;
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fails == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end
endmodule
